### sv/hse_pkg.sv
`default_nettype none

package hse_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_in;
  } hse_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } hse_out_t;

endpackage

`default_nettype wire

### sv/heap_sort_engine.sv
`default_nettype none

// Heapsort engine. Values are written one per transfer (start while busy is low) into a
// MAX_ITEMS-entry value RAM; the transfer with last_in set starts the sort, or with fewer
// than two values goes straight to the results. Values past capacity are dropped and
// flagged on every result of the set. The sort runs on a two-port RAM (one read and one
// write per cycle, registered read): a heap level of a sift-down reads the left child,
// reads the right child if the node has one, and writes the larger child or the held
// value into the hole; a build step reads the node first, a root extraction swaps the root
// with the last heap entry, and a sift-down that stops at a leaf ends with a write of the
// held value. The results leave one per cycle on result_o, marked by res_strobe_o,
// smallest first. The receiver cannot stall them. busy stays high from the last transfer
// until the final result read is issued, and no value is taken while it is high.
module heap_sort_engine #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output      logic             busy,
  input  wire hse_pkg::hse_in_t item_i,
  output      logic             res_strobe_o,
  output      hse_pkg::hse_out_t result_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DW = hse_pkg::DataW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TOP  = 4'd1;
  localparam logic [3:0] ST_HELD = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_RDL  = 4'd4;
  localparam logic [3:0] ST_RDR  = 4'd5;
  localparam logic [3:0] ST_DEC  = 4'd6;
  localparam logic [3:0] ST_SW0  = 4'd7;
  localparam logic [3:0] ST_SW1  = 4'd8;
  localparam logic [3:0] ST_SW2  = 4'd9;
  localparam logic [3:0] ST_EMIT = 4'd10;

  localparam logic PH_BUILD   = 1'b0;
  localparam logic PH_EXTRACT = 1'b1;

  logic signed [DW-1:0] mem [MAX_ITEMS];
  logic signed [DW-1:0] rdata_q;
  logic                 we;
  logic [AW-1:0]        wa, ra;
  logic signed [DW-1:0] wd;

  logic [3:0]           state_q, state_d;
  logic                 phase_q, phase_d;
  logic [CW-1:0]        count_q, count_d;
  logic                 ovf_q, ovf_d;
  logic [AW-1:0]        i_q, i_d;
  logic [AW-1:0]        hole_q, hole_d;
  logic [AW-1:0]        end_q, end_d;
  logic [AW-1:0]        child_q, child_d;
  logic [AW-1:0]        bigidx_q, bigidx_d;
  logic [AW-1:0]        k_q, k_d;
  logic signed [DW-1:0] held_q, held_d;
  logic signed [DW-1:0] big_q, big_d;
  logic signed [DW-1:0] cl_q, cl_d;
  logic signed [DW-1:0] t0_q, t0_d;
  logic                 out_v_q, out_v_d;
  logic                 out_last_q, out_last_d;
  logic                 out_ovf_q, out_ovf_d;

  logic                 accept;
  logic [CW-1:0]        n_new;
  logic [AW:0]          child_w;
  logic                 sd_done;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign child_w = {hole_q, 1'b1};
  assign n_new   = (count_q < CW'(MAX_ITEMS)) ? count_q + CW'(1) : count_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    hole_d     = hole_q;
    end_d      = end_q;
    child_d    = child_q;
    bigidx_d   = bigidx_q;
    k_d        = k_q;
    held_d     = held_q;
    big_d      = big_q;
    cl_d       = cl_q;
    t0_d       = t0_q;
    out_v_d    = 1'b0;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    we         = 1'b0;
    wa         = hole_q;
    wd         = held_q;
    ra         = i_q;
    sd_done    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < CW'(MAX_ITEMS)) begin
            we      = 1'b1;
            wa      = count_q[AW-1:0];
            wd      = item_i.value;
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (item_i.last_in) begin
            count_d = n_new;
            if (n_new < CW'(2)) begin
              k_d     = '0;
              state_d = ST_EMIT;
            end else begin
              phase_d = PH_BUILD;
              i_d     = AW'((n_new >> 1) - CW'(1));
              end_d   = AW'(n_new - CW'(1));
              state_d = ST_TOP;
            end
          end
        end
      end
      ST_TOP: begin
        ra      = i_q;
        hole_d  = i_q;
        state_d = ST_HELD;
      end
      ST_HELD: begin
        held_d  = rdata_q;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (child_w > {1'b0, end_q}) begin
          we      = 1'b1;
          wa      = hole_q;
          wd      = held_q;
          sd_done = 1'b1;
        end else begin
          ra      = child_w[AW-1:0];
          child_d = child_w[AW-1:0];
          state_d = ST_RDL;
        end
      end
      ST_RDL: begin
        cl_d = rdata_q;
        if (child_q < end_q) begin
          ra      = child_q + AW'(1);
          state_d = ST_RDR;
        end else begin
          big_d    = rdata_q;
          bigidx_d = child_q;
          state_d  = ST_DEC;
        end
      end
      ST_RDR: begin
        if (cl_q < rdata_q) begin
          big_d    = rdata_q;
          bigidx_d = child_q + AW'(1);
        end else begin
          big_d    = cl_q;
          bigidx_d = child_q;
        end
        state_d = ST_DEC;
      end
      ST_DEC: begin
        we = 1'b1;
        wa = hole_q;
        if (held_q < big_q) begin
          wd      = big_q;
          hole_d  = bigidx_q;
          state_d = ST_CHK;
        end else begin
          wd      = held_q;
          sd_done = 1'b1;
        end
      end
      ST_SW0: begin
        ra      = '0;
        state_d = ST_SW1;
      end
      ST_SW1: begin
        t0_d    = rdata_q;
        ra      = i_q;
        state_d = ST_SW2;
      end
      ST_SW2: begin
        held_d  = rdata_q;
        we      = 1'b1;
        wa      = i_q;
        wd      = t0_q;
        hole_d  = '0;
        end_d   = i_q - AW'(1);
        state_d = ST_CHK;
      end
      ST_EMIT: begin
        ra         = k_q;
        out_v_d    = 1'b1;
        out_ovf_d  = ovf_q;
        out_last_d = (CW'(k_q) + CW'(1) == count_q);
        k_d        = k_q + AW'(1);
        if (CW'(k_q) + CW'(1) == count_q) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (sd_done) begin
      if (phase_q == PH_BUILD) begin
        if (i_q == '0) begin
          phase_d = PH_EXTRACT;
          i_d     = end_q;
          state_d = ST_SW0;
        end else begin
          i_d     = i_q - AW'(1);
          state_d = ST_TOP;
        end
      end else begin
        if (i_q == AW'(1)) begin
          k_d     = '0;
          state_d = ST_EMIT;
        end else begin
          i_d     = i_q - AW'(1);
          state_d = ST_SW0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_BUILD;
      count_q <= '0;
      ovf_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    hole_q     <= hole_d;
    end_q      <= end_d;
    child_q    <= child_d;
    bigidx_q   <= bigidx_d;
    k_q        <= k_d;
    held_q     <= held_d;
    big_q      <= big_d;
    cl_q       <= cl_d;
    t0_q       <= t0_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign res_strobe_o          = out_v_q;
  assign result_o.sorted_value = rdata_q;
  assign result_o.last_out     = out_last_q;
  assign result_o.overflow     = out_ovf_q;

endmodule

`default_nettype wire
